>>> rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the shape fill rasterizer
// Register codes, shape modes, channel words, controller/datapath structs.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // internal signed geometry width, holds px << FRAC_BITS doubled plus anchor terms
  localparam int GW        = 26;
  localparam int CFG_IDX_W = 4;
  localparam int MUL_AW    = 64;
  localparam int MUL_BW    = 32;
  localparam int MUL_CW    = $clog2(MUL_BW);

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_X   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_Y   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 4'd7;

  localparam logic [2:0] MODE_FILL_RECT    = 3'd0;
  localparam logic [2:0] MODE_OUTLINE_RECT = 3'd1;
  localparam logic [2:0] MODE_ROUND_RECT   = 3'd2;
  localparam logic [2:0] MODE_FILL_ELLIPSE = 3'd3;
  localparam logic [2:0] MODE_ELLIPSE_RING = 3'd4;

  typedef struct packed {
    logic [2:0]  shape_mode;
    logic [15:0] anchor_x;
    logic [15:0] anchor_y;
    logic [14:0] span_x;
    logic [14:0] span_y;
    logic [14:0] corner_x;
    logic [14:0] corner_y;
    logic [31:0] fill_color;
  } shape_cfg_t;

  typedef struct packed {
    logic start_req;
  } req_word_t;

  typedef struct packed {
    logic        write_enable;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [31:0] pixel_value;
    logic        busy_res;
    logic        done_res;
  } res_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          wdata;
  } cfg_word_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_EMPTY,
    RES_PIXEL
  } res_kind_e;

  typedef struct packed {
    logic      latch;
    logic      box;
    logic      init_walk;
    logic      pre_sq;
    logic      pix_sq;
    logic      mul_go;
    logic      mul_pix;
    logic      save_pre;
    logic      res_load;
    res_kind_e res_kind;
    logic      advance;
  } dp_cmd_t;

  typedef struct packed {
    logic quad_mode;
    logic box_empty;
    logic last;
    logic mul_busy;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX,
    ST_CHECK,
    ST_PRE_SQ,
    ST_PRE_GO,
    ST_PRE_WAIT,
    ST_PIX,
    ST_PIX_GO,
    ST_PIX_WAIT,
    ST_RESULT,
    ST_OUT
  } ctrl_state_e;

endpackage

>>> rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if: valid/ready channels of the shape fill rasterizer
// Tick request, pixel result and register write channels.
// ----------------------------------------------------------------------------
interface sfr_req_if;
  logic                valid;
  logic                ready;
  sfr_pkg::req_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfr_res_if;
  logic                valid;
  logic                ready;
  sfr_pkg::res_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfr_cfg_if;
  logic                valid;
  logic                ready;
  sfr_pkg::cfg_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sfr_mul.sv
// ----------------------------------------------------------------------------
// sfr_mul: shift-add multiplier
// One multiplier bit per cycle, product kept modulo 2^64.
// ----------------------------------------------------------------------------
module sfr_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sfr_pkg::MUL_AW-1:0] a_i,
  input  logic [sfr_pkg::MUL_BW-1:0] b_i,
  output logic                       busy_o,
  output logic [sfr_pkg::MUL_AW-1:0] p_o
);

  logic                       busy_q;
  logic [sfr_pkg::MUL_CW-1:0] cnt_q;
  logic [sfr_pkg::MUL_AW-1:0] acc_q, a_q;
  logic [sfr_pkg::MUL_BW-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == sfr_pkg::MUL_CW'(sfr_pkg::MUL_BW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;

endmodule

>>> rtl/sfr_datapath.sv
// ----------------------------------------------------------------------------
// sfr_datapath: shape latch, bounding box, walk counters and coverage test
// Driven step by step by sfr_ctrl; two shift-add multipliers do wide products.
// ----------------------------------------------------------------------------
module sfr_datapath #(
  parameter int FRAME_WIDTH  = 2048,
  parameter int FRAME_HEIGHT = 2048,
  parameter int FRAC_BITS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfr_pkg::shape_cfg_t cfg_i,
  input  sfr_pkg::dp_cmd_t    cmd_i,
  output sfr_pkg::dp_stat_t   stat_o,
  output sfr_pkg::res_word_t  res_o
);

  localparam int GW = sfr_pkg::GW;
  typedef logic signed [GW-1:0] geo_t;
  typedef struct packed {
    geo_t lo;
    geo_t hi;
  } span_t;

  localparam geo_t FW_S = geo_t'(FRAME_WIDTH);
  localparam geo_t FH_S = geo_t'(FRAME_HEIGHT);

  function automatic geo_t fl(geo_t v);
    fl = v >>> FRAC_BITS;
  endfunction

  function automatic span_t axis_box(logic [2:0] m, geo_t a, geo_t sp, geo_t s);
    span_t r;
    geo_t  lo, hi;
    logic  inc;
    lo  = a;
    hi  = a + sp;
    inc = 1'b0;
    case (m)
      sfr_pkg::MODE_OUTLINE_RECT: begin
        if (a + sp - s < a) lo = a + sp - s;
        if (a + s > a + sp) hi = a + s;
      end
      sfr_pkg::MODE_FILL_ELLIPSE: begin
        lo  = a - sp;
        inc = 1'b1;
      end
      sfr_pkg::MODE_ELLIPSE_RING: begin
        lo  = a - sp - s;
        hi  = a + sp + s;
        inc = 1'b1;
      end
      default: ;
    endcase
    r.lo = fl(lo);
    r.hi = fl(hi) + {{(GW-1){1'b0}}, inc};
    return r;
  endfunction

  // distance into a corner zone, all terms doubled
  function automatic geo_t zone(geo_t p, geo_t lo, geo_t len, geo_t r);
    geo_t z;
    if (p < lo + r) z = lo + r - p;
    else if (p > lo + len - r) z = p - (lo + len - r);
    else z = '0;
    return z;
  endfunction

  sfr_pkg::shape_cfg_t l_q;
  logic [11:0] walk_x_q, walk_y_q, row_begin_q, box_y0_q, box_end_x_q, box_end_y_q;
  logic        empty_q;
  logic [31:0] ux2_q, uy2_q, e2_q;
  logic [63:0] d2_q, f2_q, c_q, r1_q;
  sfr_pkg::res_word_t res_q, res_d;

  // shape terms
  geo_t ax, ay, sx, sy, sc;
  logic [15:0] cx2, cy2, sx16, sy16, rx, ry, ux, uy, e16;
  geo_t rxg, ryg;
  logic quad, round_m, defined_m;

  always_comb begin
    ax   = {{(GW-16){l_q.anchor_x[15]}}, l_q.anchor_x};
    ay   = {{(GW-16){l_q.anchor_y[15]}}, l_q.anchor_y};
    sx   = {{(GW-15){1'b0}}, l_q.span_x};
    sy   = {{(GW-15){1'b0}}, l_q.span_y};
    sc   = {{(GW-15){1'b0}}, l_q.corner_x};
    cx2  = {l_q.corner_x, 1'b0};
    cy2  = {l_q.corner_y, 1'b0};
    sx16 = {1'b0, l_q.span_x};
    sy16 = {1'b0, l_q.span_y};
    rx   = (cx2 < sx16) ? cx2 : sx16;
    ry   = (cy2 < sy16) ? cy2 : sy16;
    rxg  = {{(GW-16){1'b0}}, rx};
    ryg  = {{(GW-16){1'b0}}, ry};
    round_m   = (l_q.shape_mode == sfr_pkg::MODE_ROUND_RECT);
    quad      = l_q.shape_mode inside {sfr_pkg::MODE_ROUND_RECT, sfr_pkg::MODE_FILL_ELLIPSE,
                                       sfr_pkg::MODE_ELLIPSE_RING};
    defined_m = l_q.shape_mode <= sfr_pkg::MODE_ELLIPSE_RING;
    ux   = round_m ? rx : sx16;
    uy   = round_m ? ry : sy16;
    e16  = sx16 + {1'b0, l_q.corner_x};
  end

  // bounding box, clipped to the frame
  span_t bx, by;
  geo_t  x0c, x1c, y0c, y1c, xe, ye;
  logic  box_empty;

  always_comb begin
    bx  = axis_box(l_q.shape_mode, ax, sx, sc);
    by  = axis_box(l_q.shape_mode, ay, sy, sc);
    x0c = (bx.lo < 0) ? '0 : bx.lo;
    y0c = (by.lo < 0) ? '0 : by.lo;
    x1c = (bx.hi > FW_S) ? FW_S : bx.hi;
    y1c = (by.hi > FH_S) ? FH_S : by.hi;
    xe  = x1c - geo_t'(1);
    ye  = y1c - geo_t'(1);
    box_empty = !defined_m || (x0c >= x1c) || (y0c >= y1c);
  end

  // pixel geometry
  geo_t px, py, pp, qq, nx, ny, dd, ff;
  logic signed [2*GW-1:0] d_sq, f_sq;

  always_comb begin
    px   = {{(GW-12){1'b0}}, walk_x_q};
    py   = {{(GW-12){1'b0}}, walk_y_q};
    pp   = px <<< FRAC_BITS;
    qq   = py <<< FRAC_BITS;
    nx   = zone(pp <<< 1, ax <<< 1, sx <<< 1, rxg);
    ny   = zone(qq <<< 1, ay <<< 1, sy <<< 1, ryg);
    dd   = round_m ? nx : pp - ax;
    ff   = round_m ? ny : qq - ay;
    d_sq = dd * dd;
    f_sq = ff * ff;
  end

  // wide products
  logic [63:0] m0_a, m1_a, p0, p1, nsum;
  logic [31:0] m1_b;
  logic        busy0, busy1;

  assign m0_a = cmd_i.mul_pix ? d2_q : {32'd0, ux2_q};
  assign m1_a = cmd_i.mul_pix ? f2_q : {32'd0, e2_q};
  assign m1_b = cmd_i.mul_pix ? ux2_q : uy2_q;

  sfr_mul u_mul0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .a_i     (m0_a),
    .b_i     (uy2_q),
    .busy_o  (busy0),
    .p_o     (p0)
  );

  sfr_mul u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .a_i     (m1_a),
    .b_i     (m1_b),
    .busy_o  (busy1),
    .p_o     (p1)
  );

  assign nsum = p0 + p1;

  // coverage
  logic cov, inx, iny, ezero, last;

  always_comb begin
    inx   = (px >= fl(ax)) && (px < fl(ax + sx));
    iny   = (py >= fl(ay)) && (py < fl(ay + sy));
    ezero = (l_q.span_x == '0) || (l_q.span_y == '0);
    case (l_q.shape_mode)
      sfr_pkg::MODE_FILL_RECT:    cov = 1'b1;
      sfr_pkg::MODE_OUTLINE_RECT: begin
        cov = (inx && (py < fl(ay + sc))) || (inx && (py >= fl(ay + sy - sc))) ||
              (iny && (px < fl(ax + sc))) || (iny && (px >= fl(ax + sx - sc)));
      end
      sfr_pkg::MODE_ROUND_RECT: begin
        if (rx == '0 && ry == '0) cov = 1'b1;
        else if (rx == '0)        cov = (ny <= ryg);
        else if (ry == '0)        cov = (nx <= rxg);
        else                      cov = (nsum <= c_q);
      end
      sfr_pkg::MODE_FILL_ELLIPSE: cov = !ezero && (nsum <= c_q);
      sfr_pkg::MODE_ELLIPSE_RING: cov = !ezero && (nsum >= c_q) && (nsum <= r1_q);
      default:                    cov = 1'b0;
    endcase
    last = (walk_x_q == box_end_x_q) && (walk_y_q == box_end_y_q);
  end

  // result word for the current command
  always_comb begin
    res_d = '0;
    case (cmd_i.res_kind)
      sfr_pkg::RES_EMPTY: res_d.done_res = 1'b1;
      sfr_pkg::RES_PIXEL: begin
        res_d.write_enable = cov;
        res_d.pixel_x      = walk_x_q[10:0];
        res_d.pixel_y      = walk_y_q[10:0];
        res_d.pixel_value  = l_q.fill_color;
        res_d.busy_res     = 1'b1;
        res_d.done_res     = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      row_begin_q <= '0;
      box_y0_q    <= '0;
      box_end_x_q <= '0;
      box_end_y_q <= '0;
      empty_q     <= 1'b0;
    end else begin
      if (cmd_i.box) begin
        row_begin_q <= x0c[11:0];
        box_y0_q    <= y0c[11:0];
        box_end_x_q <= xe[11:0];
        box_end_y_q <= ye[11:0];
        empty_q     <= box_empty;
      end
      if (cmd_i.init_walk) begin
        walk_x_q <= row_begin_q;
        walk_y_q <= box_y0_q;
      end else if (cmd_i.advance && !last) begin
        if (walk_x_q == box_end_x_q) begin
          walk_x_q <= row_begin_q;
          walk_y_q <= walk_y_q + 1'b1;
        end else begin
          walk_x_q <= walk_x_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) l_q <= cfg_i;
    if (cmd_i.pre_sq) begin
      ux2_q <= ux * ux;
      uy2_q <= uy * uy;
      e2_q  <= e16 * e16;
    end
    if (cmd_i.pix_sq) begin
      d2_q <= {{(64-2*GW){1'b0}}, d_sq};
      f2_q <= {{(64-2*GW){1'b0}}, f_sq};
    end
    if (cmd_i.save_pre) begin
      c_q  <= p0;
      r1_q <= p1;
    end
    if (cmd_i.res_load) res_q <= res_d;
  end

  assign stat_o.quad_mode = quad;
  assign stat_o.box_empty = empty_q;
  assign stat_o.last      = last;
  assign stat_o.mul_busy  = busy0 | busy1;
  assign res_o            = res_q;

endmodule

>>> rtl/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl: sequencer of the shape fill rasterizer
// Takes one tick, steps the datapath through box, products and result.
// ----------------------------------------------------------------------------
module sfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic              start_req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output sfr_pkg::dp_cmd_t  cmd_o,
  input  sfr_pkg::dp_stat_t stat_i
);

  sfr_pkg::ctrl_state_e state_q, state_d;
  logic walking_q, walking_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sfr_pkg::ST_IDLE;
      walking_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      walking_q <= walking_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    walking_d      = walking_q;
    cmd_o          = '0;
    cmd_o.res_kind = sfr_pkg::RES_ZERO;
    req_ready_o    = 1'b0;
    res_valid_o    = 1'b0;
    case (state_q)
      sfr_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (walking_q) begin
            state_d = sfr_pkg::ST_PIX;
          end else if (start_req_i) begin
            cmd_o.latch = 1'b1;
            state_d     = sfr_pkg::ST_BOX;
          end else begin
            cmd_o.res_load = 1'b1;
            state_d        = sfr_pkg::ST_OUT;
          end
        end
      end
      sfr_pkg::ST_BOX: begin
        cmd_o.box = 1'b1;
        state_d   = sfr_pkg::ST_CHECK;
      end
      sfr_pkg::ST_CHECK: begin
        if (stat_i.box_empty) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = sfr_pkg::RES_EMPTY;
          state_d        = sfr_pkg::ST_OUT;
        end else begin
          cmd_o.init_walk = 1'b1;
          walking_d       = 1'b1;
          state_d         = stat_i.quad_mode ? sfr_pkg::ST_PRE_SQ : sfr_pkg::ST_PIX;
        end
      end
      sfr_pkg::ST_PRE_SQ: begin
        cmd_o.pre_sq = 1'b1;
        state_d      = sfr_pkg::ST_PRE_GO;
      end
      sfr_pkg::ST_PRE_GO: begin
        cmd_o.mul_go = 1'b1;
        state_d      = sfr_pkg::ST_PRE_WAIT;
      end
      sfr_pkg::ST_PRE_WAIT: begin
        if (!stat_i.mul_busy) begin
          cmd_o.save_pre = 1'b1;
          state_d        = sfr_pkg::ST_PIX;
        end
      end
      sfr_pkg::ST_PIX: begin
        if (stat_i.quad_mode) begin
          cmd_o.pix_sq = 1'b1;
          state_d      = sfr_pkg::ST_PIX_GO;
        end else begin
          state_d = sfr_pkg::ST_RESULT;
        end
      end
      sfr_pkg::ST_PIX_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_pix = 1'b1;
        state_d       = sfr_pkg::ST_PIX_WAIT;
      end
      sfr_pkg::ST_PIX_WAIT: begin
        cmd_o.mul_pix = 1'b1;
        if (!stat_i.mul_busy) state_d = sfr_pkg::ST_RESULT;
      end
      sfr_pkg::ST_RESULT: begin
        cmd_o.mul_pix  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = sfr_pkg::RES_PIXEL;
        cmd_o.advance  = 1'b1;
        if (stat_i.last) walking_d = 1'b0;
        state_d = sfr_pkg::ST_OUT;
      end
      sfr_pkg::ST_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = sfr_pkg::ST_IDLE;
      end
      default: state_d = sfr_pkg::ST_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && res_valid_o))
    else $error("tick taken while a word is pending");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(walking_q) |-> $past(stat_i.last) && $past(state_q == sfr_pkg::ST_RESULT))
    else $error("walk ended before last pixel");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_go |-> !stat_i.mul_busy)
    else $error("multiplier restarted while busy");

  a_tick_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> state_q != sfr_pkg::ST_IDLE)
    else $error("accepted tick produced no work");

endmodule

>>> rtl/shape_fill_rasterizer.sv
// ----------------------------------------------------------------------------
// shape_fill_rasterizer: bounding-box shape rasterizer
// Register file, sequencer and datapath for five shape modes.
// ----------------------------------------------------------------------------
// Each tick on req_if gives exactly one word on res_if. A start tick while idle
// latches the registers, clips the shape's box to the frame and reports the
// first pixel, or a done word if the box is empty; later ticks report the
// following pixels in raster order until done_res, and a plain tick while
// idle gives an all-zero word. Ticks are handled one at a time; rounded
// rectangles and ellipses wait on the 32-step shift-add multipliers forming
// the squared compares, and a start tick in those modes first forms the
// per-shape radius products. Registers may be written at any time through
// cfg_if; they take effect at the next start tick.
module shape_fill_rasterizer #(
  parameter int FRAME_WIDTH  = 2048,
  parameter int FRAME_HEIGHT = 2048,
  parameter int FRAC_BITS    = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_req_if.sink    req_if,
  sfr_res_if.source  res_if,
  sfr_cfg_if.sink    cfg_if
);

  sfr_pkg::shape_cfg_t cfg_q;
  sfr_pkg::dp_cmd_t    cmd;
  sfr_pkg::dp_stat_t   stat;
  sfr_pkg::res_word_t  res_word;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.reg_index)
        sfr_pkg::REG_SHAPE_MODE: cfg_q.shape_mode <= cfg_if.data.wdata[2:0];
        sfr_pkg::REG_ANCHOR_X:   cfg_q.anchor_x   <= cfg_if.data.wdata[15:0];
        sfr_pkg::REG_ANCHOR_Y:   cfg_q.anchor_y   <= cfg_if.data.wdata[15:0];
        sfr_pkg::REG_SPAN_X:     cfg_q.span_x     <= cfg_if.data.wdata[14:0];
        sfr_pkg::REG_SPAN_Y:     cfg_q.span_y     <= cfg_if.data.wdata[14:0];
        sfr_pkg::REG_CORNER_X:   cfg_q.corner_x   <= cfg_if.data.wdata[14:0];
        sfr_pkg::REG_CORNER_Y:   cfg_q.corner_y   <= cfg_if.data.wdata[14:0];
        sfr_pkg::REG_FILL_COLOR: cfg_q.fill_color <= cfg_if.data.wdata;
        default: ;
      endcase
    end
  end

  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_if.ready),
    .start_req_i (req_if.data.start_req),
    .res_valid_o (res_if.valid),
    .res_ready_i (res_if.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  sfr_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_word)
  );

  assign res_if.data = res_word;

endmodule
